>>> rtl/ieca_pkg.sv
// Package for the expected-count accumulator: sizes, commands, item and
// row types, FSM states and the saturating add. No dependencies.
package ieca_pkg;

  localparam int NODES    = 32;
  localparam int ITEMS    = 16;
  localparam int ACC_BITS = 48;

  localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ITEM_AW  = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam int PROD_W   = 33;
  localparam int POST_W   = 17;
  localparam logic [POST_W-1:0] POST_ONE = POST_W'(65536);

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  node;
    logic [15:0] weight;
    logic [16:0] posterior;
    logic [15:0] answered_bits;
    logic [15:0] correct_bits;
    logic [3:0]  item;
  } in_item_t;

  typedef struct packed {
    logic [47:0] node_total;
    logic [47:0] item_attempts;
    logic [47:0] item_correct;
  } out_item_t;

  // One memory row holds everything kept for one node.
  typedef struct packed {
    logic [ACC_BITS-1:0]             node_total;
    logic [ITEMS-1:0][ACC_BITS-1:0]  attempts;
    logic [ITEMS-1:0][ACC_BITS-1:0]  correct;
  } row_t;

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [PROD_W-1:0]   b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS + 1)'(b);
    return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
  endfunction

endpackage

>>> rtl/ieca_if.sv
// Valid/ready channels for input items and result items.
// Depends on ieca_pkg.
interface ieca_in_if;
  import ieca_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ieca_out_if;
  import ieca_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ieca_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ieca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/ieca_row_update.sv
// Per-item lane update of one node row: saturating adds of the product
// into the node total and the answered / correct lanes. Depends on ieca_pkg.
module ieca_row_update (
  input  ieca_pkg::row_t                   row_i,
  input  logic [ieca_pkg::PROD_W-1:0]      prod_i,
  input  logic [ieca_pkg::ITEMS-1:0]       answered_i,
  input  logic [ieca_pkg::ITEMS-1:0]       correct_i,
  output ieca_pkg::row_t                   row_o
);
  import ieca_pkg::*;

  always_comb begin
    row_o.node_total = sat_add(row_i.node_total, prod_i);
    for (int j = 0; j < ITEMS; j++) begin
      row_o.attempts[j] = answered_i[j] ? sat_add(row_i.attempts[j], prod_i)
                                        : row_i.attempts[j];
      row_o.correct[j]  = (answered_i[j] && correct_i[j])
                          ? sat_add(row_i.correct[j], prod_i) : row_i.correct[j];
    end
  end

endmodule

>>> rtl/irt_expected_count_accumulator.sv
// Expected-count accumulator top level. Depends on ieca_pkg, ieca_if,
// ieca_ram and ieca_row_update.
//
// All sums live in one 32-row memory, one row per ability node holding the
// node total and the attempt and correct counts of all 16 items. For an
// accumulate item the row is read while weight * posterior is registered,
// then all lanes are updated with saturating adds and the row is written
// back; no item is accepted during this read-modify-write. A read item
// lands in an output register once that register is free, so the next
// item is accepted while the result waits. After reset and after a clear
// item the block sweeps the memory, one row a cycle, and accepts no item
// during the sweep.
module irt_expected_count_accumulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  ieca_in_if.sink       in_i,
  ieca_out_if.source    out_o
);
  import ieca_pkg::*;

  state_e               state_q, state_d;
  logic [NODE_AW-1:0]   cnt_q, cnt_d;
  logic [NODE_AW-1:0]   node_q;
  logic                 node_ok_q;
  logic                 item_ok_q;
  logic [ITEM_AW-1:0]   item_q;
  logic [ITEMS-1:0]     ans_q;
  logic [ITEMS-1:0]     cor_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  out_item_t            out_data_q;

  logic                 accept;
  cmd_e                 cmd;
  logic [POST_W-1:0]    post_c;
  logic                 rd_en;
  logic                 wr_en;
  logic [NODE_AW-1:0]   wr_addr;
  row_t                 wr_row;
  row_t                 rd_row;
  row_t                 upd_row;
  logic                 load_out;
  logic                 last_row;

  assign cmd    = cmd_e'(in_i.data.command);
  assign accept = in_i.valid && in_i.ready;
  assign post_c = (in_i.data.posterior > POST_ONE) ? POST_ONE : in_i.data.posterior;
  assign last_row = (cnt_q == NODE_AW'(NODES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = last_row ? '0 : cnt_q + 1'b1;
        if (last_row) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ACC:   state_d = ST_ACC;
            CMD_READ:  state_d = ST_READ;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC:  state_d = ST_IDLE;
      ST_READ: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = node_q;
    wr_row     = upd_row;
    load_out   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_row  = '0;
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_en      = in_i.valid && (cmd == CMD_ACC || cmd == CMD_READ);
      end
      ST_ACC: begin
        wr_en = node_ok_q;
      end
      ST_READ: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q    <= in_i.data.node[NODE_AW-1:0];
      node_ok_q <= (32'(in_i.data.node) < NODES);
      item_ok_q <= (32'(in_i.data.item) < ITEMS);
      item_q    <= in_i.data.item[ITEM_AW-1:0];
      ans_q     <= in_i.data.answered_bits[ITEMS-1:0];
      cor_q     <= in_i.data.correct_bits[ITEMS-1:0];
      prod_q    <= PROD_W'(in_i.data.weight) * PROD_W'(post_c);
    end
    if (load_out) begin
      out_data_q.node_total    <= node_ok_q ? rd_row.node_total : '0;
      out_data_q.item_attempts <= (node_ok_q && item_ok_q) ? rd_row.attempts[item_q] : '0;
      out_data_q.item_correct  <= (node_ok_q && item_ok_q) ? rd_row.correct[item_q] : '0;
    end
  end

  ieca_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NODES)
  ) u_sums_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_i.data.node[NODE_AW-1:0]),
    .rd_data_o (rd_row)
  );

  ieca_row_update u_row_update (
    .row_i      (rd_row),
    .prod_i     (prod_q),
    .answered_i (ans_q),
    .correct_i  (cor_q),
    .row_o      (upd_row)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

>>> bench/tb_irt_expected_count_accumulator.sv
// Self-checking bench for irt_expected_count_accumulator: a count tally class
// mirrors the node, attempt and correct sums and checks every read result.
// Depends on ieca_pkg, ieca_if and the accumulator RTL.
`timescale 1ns / 1ps

module tb_irt_expected_count_accumulator;
  import ieca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1950;

  class count_tally;
    logic [ACC_BITS-1:0] node_sum [NODES];
    logic [ACC_BITS-1:0] attempt_sum [NODES][ITEMS];
    logic [ACC_BITS-1:0] correct_sum [NODES][ITEMS];
    out_item_t reads_due [$];
    int errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (node_sum[n]) node_sum[n] = '0;
      foreach (attempt_sum[n, j]) begin
        attempt_sum[n][j] = '0;
        correct_sum[n][j] = '0;
      end
    endfunction

    function logic [ACC_BITS-1:0] add_sat(logic [ACC_BITS-1:0] a, logic [PROD_W-1:0] p);
      logic [ACC_BITS:0] s;
      s = {1'b0, a} + (ACC_BITS + 1)'(p);
      return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
    endfunction

    function void absorb(in_item_t it);
      logic [POST_W-1:0] post;
      logic [PROD_W-1:0] prod;
      out_item_t want;
      case (cmd_e'(it.command))
        CMD_ACC: begin
          if (it.node < NODES) begin
            post = (it.posterior > POST_ONE) ? POST_ONE : it.posterior;
            prod = PROD_W'(it.weight) * PROD_W'(post);
            node_sum[it.node] = add_sat(node_sum[it.node], prod);
            for (int j = 0; j < ITEMS && j < 16; j++) begin
              if (it.answered_bits[j]) begin
                attempt_sum[it.node][j] = add_sat(attempt_sum[it.node][j], prod);
                if (it.correct_bits[j])
                  correct_sum[it.node][j] = add_sat(correct_sum[it.node][j], prod);
              end
            end
          end
        end
        CMD_READ: begin
          want = '0;
          if (it.node < NODES) begin
            want.node_total = 48'(node_sum[it.node]);
            if (it.item < ITEMS) begin
              want.item_attempts = 48'(attempt_sum[it.node][it.item]);
              want.item_correct  = 48'(correct_sum[it.node][it.item]);
            end
          end
          reads_due.push_back(want);
        end
        CMD_CLEAR: wipe();
        CMD_NOP: ;
        default: ;
      endcase
    endfunction

    function void match(string field, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      if (reads_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none got %h", $time, got);
        return;
      end
      want = reads_due.pop_front();
      match("node_total", want.node_total, got.node_total);
      match("item_attempts", want.item_attempts, got.item_attempts);
      match("item_correct", want.item_correct, got.item_correct);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  ieca_in_if  in_if ();
  ieca_out_if out_if ();

  count_tally tally = new();
  int unsigned cycle_count = 0;
  int rx_hold = 0;
  int rx_stall = 0;
  bit smooth = 1'b0;

  irt_expected_count_accumulator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) begin
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) tally.absorb(in_if.data);
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) tally.check_read(out_if.data);
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // result sink: long hold-off on request, random stalls otherwise
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!smooth && $urandom_range(0, 5) == 0) rx_stall = pick_gap();
      end
    end
  end

  function automatic in_item_t op_item(cmd_e cmd);
    in_item_t it;
    it.command       = cmd;
    it.node          = 5'($urandom);
    it.weight        = 16'($urandom);
    it.posterior     = 17'($urandom);
    it.answered_bits = 16'($urandom);
    it.correct_bits  = 16'($urandom);
    it.item          = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(int node, int item);
    in_item_t it;
    it = op_item(CMD_READ);
    it.node = 5'(node);
    it.item = 4'(item);
    return it;
  endfunction

  function automatic in_item_t acc_item(int node, logic [15:0] weight, logic [16:0] post,
                                        logic [15:0] answered, logic [15:0] correct);
    in_item_t it;
    it = op_item(CMD_ACC);
    it.node          = 5'(node);
    it.weight        = weight;
    it.posterior     = post;
    it.answered_bits = answered;
    it.correct_bits  = correct;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = op_item(cmd_e'(r < 58 ? CMD_ACC : r < 95 ? CMD_READ : r < 96 ? CMD_CLEAR : CMD_NOP));
    // hot nodes keep back-to-back updates on the same row
    if ($urandom_range(0, 1) == 0) it.node = 5'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: it.weight = 16'h0000;
      1: it.weight = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: it.posterior = POST_ONE;
      1: it.posterior = 17'($urandom_range(65537, 131071));
      2: it.posterior = '0;
      default: it.posterior = 17'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 7) == 0) it.answered_bits = 16'hFFFF;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (!smooth && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic wait_reads_done();
    // let the monitor note the last accepted item first
    @(negedge clk_i);
    while (tally.reads_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int counted;
    in_item_t it;
    counted = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, clamp, correct-without-answer, no-op, clear
    send_item(read_item(0, 0));
    send_item(acc_item(0, 16'hFFFF, POST_ONE, 16'hFFFF, 16'hFFFF));
    send_item(acc_item(0, 16'h0001, 17'd1, 16'h0000, 16'hFFFF));
    send_item(acc_item(31, 16'h8000, 17'h1FFFF, 16'hAAAA, 16'h5555));
    send_item(acc_item(31, 16'h0100, 17'd65537, 16'h5555, 16'hFFFF));
    send_item(acc_item(5, 16'h0000, 17'd0, 16'hFFFF, 16'hFFFF));
    send_item(op_item(CMD_NOP));
    send_item(read_item(0, 0));
    send_item(read_item(0, 15));
    send_item(read_item(0, 7));
    send_item(read_item(31, 0));
    send_item(read_item(31, 1));
    send_item(read_item(31, 15));
    send_item(read_item(5, 3));
    send_item(op_item(CMD_CLEAR));
    send_item(read_item(0, 0));
    send_item(read_item(31, 15));
    send_item(acc_item(0, 16'hFFFF, POST_ONE, 16'h0001, 16'h0001));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    in_if.valid <= 1'b0;
    wait_reads_done();

    // back-pressure: sink holds off while the source keeps offering
    @(negedge clk_i);
    rx_hold = 300;
    smooth = 1'b1;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) send_item(acc_item(k % 4, 16'($urandom), 17'($urandom_range(0, 65536)),
                                         16'($urandom), 16'($urandom)));
      else send_item(read_item(k % 4, $urandom_range(0, 15)));
    end
    in_if.valid <= 1'b0;
    wait_reads_done();
    smooth = 1'b0;

    while (counted < RANDOM_ITEMS) begin
      if (counted % 150 == 0) smooth = ($urandom_range(0, 3) == 0);
      it = random_item();
      send_item(it);
      if (cmd_e'(it.command) != CMD_NOP) counted++;
      if ($urandom_range(0, 299) == 0) begin
        in_if.valid <= 1'b0;
        wait_reads_done();
      end
    end
    in_if.valid <= 1'b0;
    smooth = 1'b0;

    wait_reads_done();
    repeat (50) @(posedge clk_i);
    if (tally.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/ieca_pkg.sv
rtl/ieca_if.sv
rtl/ieca_ram.sv
rtl/ieca_row_update.sv
rtl/irt_expected_count_accumulator.sv
bench/tb_irt_expected_count_accumulator.sv
